// ===== rtl/qau_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_pkg
// Op codes and lane modes shared by the quaternion arithmetic unit.
// ---------------------------------------------------------------------------
package qau_pkg;

  localparam int unsigned FUNC_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MUL  = 3'd0,
    FUNC_ADD  = 3'd1,
    FUNC_SUB  = 3'd2,
    FUNC_NORM = 3'd3,
    FUNC_LERP = 3'd4
  } func_e;

  // what each lane multiplies
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_HAM  = 2'd1,
    MODE_LERP = 2'd2,
    MODE_SQR  = 2'd3
  } mode_e;

endpackage

// ===== rtl/qau_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_in_if
// Input channel: op code, two quaternions and the blend factor.
// ---------------------------------------------------------------------------
interface qau_in_if #(
  parameter int unsigned COMP_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 14
);
  logic                          valid;
  logic                          ready;
  logic [qau_pkg::FUNC_W-1:0]    func;
  logic signed [COMP_WIDTH-1:0]  a_x;
  logic signed [COMP_WIDTH-1:0]  a_y;
  logic signed [COMP_WIDTH-1:0]  a_z;
  logic signed [COMP_WIDTH-1:0]  a_w;
  logic signed [COMP_WIDTH-1:0]  b_x;
  logic signed [COMP_WIDTH-1:0]  b_y;
  logic signed [COMP_WIDTH-1:0]  b_z;
  logic signed [COMP_WIDTH-1:0]  b_w;
  logic [FRAC_BITS:0]            blend;

  modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                  input ready);
  modport sink (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                output ready);
endinterface

// ===== rtl/qau_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_out_if
// Output channel: result quaternion and status flags.
// ---------------------------------------------------------------------------
interface qau_out_if #(
  parameter int unsigned COMP_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COMP_WIDTH-1:0]  r_x;
  logic signed [COMP_WIDTH-1:0]  r_y;
  logic signed [COMP_WIDTH-1:0]  r_z;
  logic signed [COMP_WIDTH-1:0]  r_w;
  logic                          zero_norm;
  logic                          saturated;

  modport source (output valid, r_x, r_y, r_z, r_w, zero_norm, saturated, input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, zero_norm, saturated, output ready);
endinterface

// ===== rtl/qau_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_lane
// One component lane: four products, then their signed sum (two stages).
// ---------------------------------------------------------------------------
module qau_lane #(
  parameter int unsigned LANE = 0,
  parameter int unsigned OP_W = 17
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  qau_pkg::mode_e         mode_i,
  input  logic signed [OP_W-1:0] a_i [4],
  input  logic signed [OP_W-1:0] b_i [4],
  input  logic signed [OP_W-1:0] c_i [4],
  input  logic signed [OP_W-1:0] t_i,
  input  logic signed [OP_W-1:0] u_i,
  output logic signed [2*OP_W+1:0] sum_o
);

  localparam int unsigned PW    = 2 * OP_W;
  localparam int unsigned SUM_W = 2 * OP_W + 2;
  localparam int unsigned L1    = (LANE + 1) % 3;
  localparam int unsigned L2    = (LANE + 2) % 3;

  logic signed [OP_W-1:0] opx [4];
  logic signed [OP_W-1:0] opy [4];
  logic [3:0]             neg;

  logic signed [PW-1:0]    prod_q [4];
  logic [3:0]              neg_q;
  logic signed [SUM_W-1:0] sum_q;
  logic signed [SUM_W-1:0] sum_d;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      opx[k] = '0;
      opy[k] = '0;
    end
    neg = '0;
    case (mode_i)
      qau_pkg::MODE_HAM: begin
        if (LANE < 3) begin
          opx[0] = a_i[3];    opy[0] = b_i[LANE];
          opx[1] = a_i[LANE]; opy[1] = b_i[3];
          opx[2] = a_i[L1];   opy[2] = b_i[L2];
          opx[3] = a_i[L2];   opy[3] = b_i[L1];
          neg    = 4'b1000;
        end else begin
          opx[0] = a_i[3]; opy[0] = b_i[3];
          opx[1] = a_i[0]; opy[1] = b_i[0];
          opx[2] = a_i[1]; opy[2] = b_i[1];
          opx[3] = a_i[2]; opy[3] = b_i[2];
          neg    = 4'b1110;
        end
      end
      qau_pkg::MODE_LERP: begin
        opx[0] = a_i[LANE]; opy[0] = u_i;
        opx[1] = b_i[LANE]; opy[1] = t_i;
      end
      qau_pkg::MODE_SQR: begin
        opx[0] = c_i[LANE]; opy[0] = c_i[LANE];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= opx[k] * opy[k];
      end
      neg_q <= neg;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 4; k++) begin
      if (neg_q[k]) begin
        sum_d = sum_d - SUM_W'(prod_q[k]);
      end else begin
        sum_d = sum_d + SUM_W'(prod_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/qau_sqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_sqrt
// Floor integer square root, one root bit per pipeline stage.
// ---------------------------------------------------------------------------
module qau_sqrt #(
  parameter int unsigned RT_W = 18
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2*RT_W-1:0]     sq_i,
  output logic [RT_W-1:0]       root_o
);

  localparam int unsigned IN_W  = 2 * RT_W;
  localparam int unsigned REM_W = RT_W + 2;

  logic [IN_W-1:0]  sq_q   [RT_W];
  logic [REM_W-1:0] rem_q  [RT_W];
  logic [RT_W-1:0]  root_q [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    localparam int unsigned J = RT_W - 1 - k;
    logic [IN_W-1:0]  sq_p;
    logic [REM_W-1:0] rem_p;
    logic [RT_W-1:0]  root_p;
    logic [REM_W-1:0] tr;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign sq_p   = sq_i;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign sq_p   = sq_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
    end

    assign tr    = {rem_p[RT_W-1:0], sq_p[2*J+1:2*J]};
    assign trial = {root_p, 2'b01};
    assign ge    = (tr >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k]   <= sq_p;
        rem_q[k]  <= ge ? (tr - trial) : tr;
        root_q[k] <= {root_p[RT_W-2:0], ge};
      end
    end
  end

  assign root_o = root_q[RT_W-1];

endmodule

// ===== rtl/qau_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_div
// Restoring divider, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module qau_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 18,
  parameter int unsigned QUO_W = 15
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [QUO_W-1:0]  quo_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_p;
    logic [QUO_W-1:0] lo_p;
    logic [DEN_W-1:0] den_p;
    logic [QUO_W-1:0] quo_p;
    logic [DEN_W:0]   tr;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      // quotient is known to fit, so the high numerator part is below den
      assign rem_p = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign lo_p  = num_i[QUO_W-1:0];
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign lo_p  = lo_q[k-1];
      assign den_p = den_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign tr   = {rem_p, lo_p[QUO_W-1-k]};
    assign diff = tr - {1'b0, den_p};
    assign ge   = (tr >= {1'b0, den_p});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : tr[DEN_W-1:0];
        lo_q[k]  <= lo_p;
        den_q[k] <= den_p;
        quo_q[k] <= {quo_p[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

// ===== rtl/quaternion_arith_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_arith_unit
// Pipelined fixed point quaternion ALU: product, normalized sum and difference, normalize, lerp.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one op per beat: func, quaternions a and b, blend factor.
//   out_o returns one result beat per input beat, in order: r_x..r_w,
//   zero_norm and saturated.
//   Four component lanes form the products in parallel; a merge stage sums
//   the lane squares for normalization, then a root pipeline (one bit per
//   stage) and four divider lanes (one quotient bit per stage) follow.
//   A beat passes the input register, the lane stages, the root stages
//   (COMP_WIDTH + 2), the root register, the divider stages (FRAC_BITS + 1)
//   and the output register. Throughput is one beat per cycle while
//   in_i.ready is high. Every op takes the same path, so latency does not
//   depend on func. When out_o stalls, the output register holds its beat
//   and a skid register takes one more; only then does in_i.ready drop and
//   the whole pipeline freeze until the skid empties.
//   Reset clears all valid bits; nothing is in flight after reset.
// ---------------------------------------------------------------------------
module quaternion_arith_unit #(
  parameter int unsigned COMP_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qau_in_if.sink     in_i,
  qau_out_if.source  out_o
);

  localparam int unsigned W      = COMP_WIDTH;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned OP_W   = (W + 1 > F + 2) ? W + 1 : F + 2;
  localparam int unsigned SUM_W  = 2 * OP_W + 2;
  localparam int unsigned SQ_W   = 2 * W + 3;
  localparam int unsigned RT_W   = W + 2;
  localparam int unsigned SQ_PAD = 2 * RT_W;
  localparam int unsigned QUO_W  = F + 1;
  localparam int unsigned NUM_W  = W + F + 2;
  localparam int unsigned XW     = SUM_W + QUO_W + 2;
  localparam int unsigned D      = RT_W + 1 + QUO_W;

  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic signed [SUM_W:0] HALF = {{(SUM_W + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
  localparam logic signed [XW-1:0] MAXV = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [XW-1:0] MINV = ~MAXV;

  typedef struct packed {
    logic [qau_pkg::FUNC_W-1:0] func;
    logic                       zero;
    logic                       clip;
    logic [3:0][W:0]            c;
    logic [3:0][W-1:0]          res;
  } side_t;

  typedef struct packed {
    logic [3:0][W-1:0] r;
    logic              zero;
    logic              clip;
  } out_t;

  function automatic logic [W:0] sat(input logic signed [XW-1:0] v);
    logic [W:0] o;
    if (v > MAXV) begin
      o = {1'b1, MAXV[W-1:0]};
    end else if (v < MINV) begin
      o = {1'b1, MINV[W-1:0]};
    end else begin
      o = {1'b0, v[W-1:0]};
    end
    return o;
  endfunction

  logic en;
  logic skid_v_q;

  assign en         = ~skid_v_q;
  assign in_i.ready = en;

  // ---------------- input stage ----------------
  logic                       v_s1_q, v_s2_q, v_s3_q;
  logic [qau_pkg::FUNC_W-1:0] func_s1_q, func_s2_q, func_s3_q;
  qau_pkg::mode_e             mode_d, mode_s1_q;
  logic signed [OP_W-1:0]     a_s1_q [4];
  logic signed [OP_W-1:0]     b_s1_q [4];
  logic signed [OP_W-1:0]     c_s1_q [4];
  logic signed [OP_W-1:0]     c_s2_q [4];
  logic signed [OP_W-1:0]     c_s3_q [4];
  logic signed [OP_W-1:0]     t_s1_q, u_s1_q;
  logic signed [OP_W-1:0]     a_in [4];
  logic signed [OP_W-1:0]     b_in [4];
  logic signed [OP_W-1:0]     c_d  [4];
  logic [F:0]                 t_c;

  assign a_in[0] = OP_W'(in_i.a_x);
  assign a_in[1] = OP_W'(in_i.a_y);
  assign a_in[2] = OP_W'(in_i.a_z);
  assign a_in[3] = OP_W'(in_i.a_w);
  assign b_in[0] = OP_W'(in_i.b_x);
  assign b_in[1] = OP_W'(in_i.b_y);
  assign b_in[2] = OP_W'(in_i.b_z);
  assign b_in[3] = OP_W'(in_i.b_w);
  assign t_c     = (in_i.blend > ONE) ? ONE : in_i.blend;

  always_comb begin
    mode_d = qau_pkg::MODE_NONE;
    for (int k = 0; k < 4; k++) begin
      c_d[k] = a_in[k];
    end
    case (in_i.func)
      qau_pkg::FUNC_MUL:  mode_d = qau_pkg::MODE_HAM;
      qau_pkg::FUNC_ADD: begin
        mode_d = qau_pkg::MODE_SQR;
        for (int k = 0; k < 4; k++) c_d[k] = a_in[k] + b_in[k];
      end
      qau_pkg::FUNC_SUB: begin
        mode_d = qau_pkg::MODE_SQR;
        for (int k = 0; k < 4; k++) c_d[k] = a_in[k] - b_in[k];
      end
      qau_pkg::FUNC_NORM: mode_d = qau_pkg::MODE_SQR;
      qau_pkg::FUNC_LERP: mode_d = qau_pkg::MODE_LERP;
      default:            mode_d = qau_pkg::MODE_NONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func_s1_q <= in_i.func;
      mode_s1_q <= mode_d;
      a_s1_q    <= a_in;
      b_s1_q    <= b_in;
      c_s1_q    <= c_d;
      t_s1_q    <= OP_W'(t_c);
      u_s1_q    <= OP_W'(ONE - t_c);
      func_s2_q <= func_s1_q;
      func_s3_q <= func_s2_q;
      c_s2_q    <= c_s1_q;
      c_s3_q    <= c_s2_q;
    end
  end

  // ---------------- component lanes ----------------
  logic signed [SUM_W-1:0] lane_sum [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    qau_lane #(
      .LANE (l),
      .OP_W (OP_W)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .mode_i (mode_s1_q),
      .a_i    (a_s1_q),
      .b_i    (b_s1_q),
      .c_i    (c_s1_q),
      .t_i    (t_s1_q),
      .u_i    (u_s1_q),
      .sum_o  (lane_sum[l])
    );
  end

  // ---------------- merge ----------------
  logic signed [SUM_W+1:0] tot;
  logic [SQ_W-1:0]         sq_total;
  side_t                   side_d;
  logic signed [SUM_W:0]   rsum [4];
  logic signed [SUM_W:0]   rnd  [4];
  logic [W:0]              rsat [4];

  always_comb begin
    tot = '0;
    for (int l = 0; l < 4; l++) begin
      tot = tot + (SUM_W + 2)'(lane_sum[l]);
    end
    sq_total = tot[SQ_W-1:0];

    side_d.func = func_s3_q;
    side_d.zero = (sq_total == '0);
    side_d.clip = 1'b0;
    for (int l = 0; l < 4; l++) begin
      rsum[l] = (SUM_W + 1)'(lane_sum[l]) + HALF;
      rnd[l]  = rsum[l] >>> F;
      rsat[l] = sat(XW'(rnd[l]));
      side_d.res[l] = rsat[l][W-1:0];
      side_d.clip   = side_d.clip | rsat[l][W];
      side_d.c[l]   = c_s3_q[l][W:0];
    end
  end

  // ---------------- root and side delay ----------------
  logic [RT_W-1:0] root;
  side_t           side_q [D];
  logic [D-1:0]    vs_q;

  qau_sqrt #(
    .RT_W (RT_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   ({{(SQ_PAD - SQ_W){1'b0}}, sq_total}),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < D; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------- divider lanes ----------------
  logic [NUM_W-1:0] num_q [4];
  logic [RT_W-1:0]  root_q;
  logic [W:0]       mag   [4];
  logic [QUO_W-1:0] quo   [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag[l] = side_q[RT_W-1].c[l][W] ? -side_q[RT_W-1].c[l] : side_q[RT_W-1].c[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      root_q <= root;
      for (int l = 0; l < 4; l++) begin
        num_q[l] <= {1'b0, mag[l], {F{1'b0}}} + NUM_W'(root >> 1);
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_div
    qau_div #(
      .NUM_W (NUM_W),
      .DEN_W (RT_W),
      .QUO_W (QUO_W)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[l]),
      .den_i (root_q),
      .quo_o (quo[l])
    );
  end

  // ---------------- final select ----------------
  side_t                  sd;
  out_t                   fin;
  logic signed [XW-1:0]   qx   [4];
  logic [W:0]             qsat [4];

  assign sd = side_q[D-1];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qx[l]   = XW'(quo[l]);
      qx[l]   = sd.c[l][W] ? -qx[l] : qx[l];
      qsat[l] = sat(qx[l]);
    end
    fin = '0;
    case (sd.func)
      qau_pkg::FUNC_MUL, qau_pkg::FUNC_LERP: begin
        fin.r    = sd.res;
        fin.clip = sd.clip;
      end
      qau_pkg::FUNC_ADD, qau_pkg::FUNC_SUB, qau_pkg::FUNC_NORM: begin
        if (sd.zero) begin
          fin.zero = 1'b1;
        end else begin
          for (int l = 0; l < 4; l++) begin
            fin.r[l] = qsat[l][W-1:0];
            fin.clip = fin.clip | qsat[l][W];
          end
        end
      end
      default: fin = '0;
    endcase
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s1_q <= 1'b0;
      v_s2_q <= 1'b0;
      v_s3_q <= 1'b0;
      vs_q   <= '0;
    end else if (en) begin
      v_s1_q <= in_i.valid;
      v_s2_q <= v_s1_q;
      v_s3_q <= v_s2_q;
      vs_q   <= {vs_q[D-2:0], v_s3_q};
    end
  end

  // ---------------- output register and skid ----------------
  out_t out_q, skid_q;
  logic out_v_q;
  logic pop;
  logic fin_v;

  assign pop   = out_v_q & out_o.ready;
  assign fin_v = vs_q[D-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (fin_v) begin
      if (out_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (fin_v) begin
      if (out_v_q && !pop) begin
        skid_q <= fin;
      end else begin
        out_q <= fin;
      end
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.r_x       = out_q.r[0];
  assign out_o.r_y       = out_q.r[1];
  assign out_o.r_z       = out_q.r[2];
  assign out_o.r_w       = out_q.r[3];
  assign out_o.zero_norm = out_q.zero;
  assign out_o.saturated = out_q.clip;

endmodule
